FILE: design/quadcopter_cascaded_pid_mixer_unit_assert.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and arst_n in scope.
`ifndef QUADCOPTER_CASCADED_PID_MIXER_UNIT_ASSERT_SVH
`define QUADCOPTER_CASCADED_PID_MIXER_UNIT_ASSERT_SVH

// same-cycle implication
`define QCPID_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qcpid check failed");

// next-cycle implication
`define QCPID_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qcpid check failed");

`endif

FILE: design/qcpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qcpid_pkg;

	// configuration port
	localparam int PADDR_W = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_ROLL_RATE_KP   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROLL_RATE_KD   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_RATE_KP  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_RATE_KD  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_YAW_RATE_KP    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROLL_ANGLE_KP  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PITCH_ANGLE_KP = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_YAW_ANGLE_KP   = 3'd7;

	localparam logic [15:0] RST_ROLL_RATE_KP   = 16'd8960;
	localparam logic [15:0] RST_ROLL_RATE_KD   = 16'd90;
	localparam logic [15:0] RST_PITCH_RATE_KP  = 16'd6400;
	localparam logic [15:0] RST_PITCH_RATE_KD  = 16'd64;
	localparam logic [15:0] RST_YAW_RATE_KP    = 16'd768;
	localparam logic [15:0] RST_ROLL_ANGLE_KP  = 16'd26;
	localparam logic [15:0] RST_PITCH_ANGLE_KP = 16'd31;
	localparam logic [15:0] RST_YAW_ANGLE_KP   = 16'd205;

	// arithmetic constants
	localparam logic [13:0] STICK_CENTER = 14'd1500;
	localparam logic [11:0] DISARM_LEVEL = 12'd1000;
	localparam logic [11:0] DISARM_PULSE = 12'd997;
	localparam logic [11:0] MOTOR_MAX    = 12'd4095;
	localparam logic [23:0] ERR_MAX      = 24'h7FFFFF;
	localparam logic [23:0] ERR_MIN      = 24'h800000;
	// x / 25600 = (|x| >> 10) / 25; n / 25 = (n * RECIP_25) >> 36, exact for n < 2^31
	localparam logic [31:0] RECIP_25     = 32'd2748779070;

	// axis codes
	localparam logic [1:0] AXIS_ROLL  = 2'd0;
	localparam logic [1:0] AXIS_PITCH = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	// datapath operations
	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_MUL     = 4'd2;
	localparam logic [3:0] OP_RERR    = 4'd3;
	localparam logic [3:0] OP_ACC_LD  = 4'd4;
	localparam logic [3:0] OP_ACC_ADD = 4'd5;
	localparam logic [3:0] OP_DIVPREP = 4'd6;
	localparam logic [3:0] OP_CORR    = 4'd7;
	localparam logic [3:0] OP_MIX     = 4'd8;

	// multiplier operand selection
	localparam logic [1:0] MS_ANGLE = 2'd0;
	localparam logic [1:0] MS_KP    = 2'd1;
	localparam logic [1:0] MS_KD    = 2'd2;
	localparam logic [1:0] MS_RECIP = 2'd3;

	// hold conditions
	localparam logic [1:0] HOLD_NONE     = 2'd0;
	localparam logic [1:0] HOLD_NO_ITEM  = 2'd1;
	localparam logic [1:0] HOLD_OUT_BUSY = 2'd2;

	// jump conditions
	localparam logic [1:0] J_NONE   = 2'd0;
	localparam logic [1:0] J_ALWAYS = 2'd1;
	localparam logic [1:0] J_YAW    = 2'd2;
	localparam logic [1:0] J_MORE   = 2'd3;

	// program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
	localparam logic [STEP_W-1:0] ST_ANG_MUL = 4'd1;
	localparam logic [STEP_W-1:0] ST_RERR    = 4'd2;
	localparam logic [STEP_W-1:0] ST_KP_MUL  = 4'd3;
	localparam logic [STEP_W-1:0] ST_ACC_LD  = 4'd4;
	localparam logic [STEP_W-1:0] ST_KD_MUL  = 4'd5;
	localparam logic [STEP_W-1:0] ST_ACC_ADD = 4'd6;
	localparam logic [STEP_W-1:0] ST_DIVPREP = 4'd7;
	localparam logic [STEP_W-1:0] ST_RCP_MUL = 4'd8;
	localparam logic [STEP_W-1:0] ST_CORR    = 4'd9;
	localparam logic [STEP_W-1:0] ST_MIX     = 4'd10;

	typedef struct packed {
		logic [3:0]        op;
		logic [1:0]        msel;
		logic [1:0]        hold;
		logic [1:0]        jcond;
		logic [STEP_W-1:0] jtarget;
	} cword_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] msel;
		logic       exec;
		logic       idle;
	} seq_ctrl_t;

	typedef struct packed {
		logic item_valid;
		logic out_busy;
		logic axis_yaw;
	} seq_stat_t;

	function automatic cword_t ucode(input logic [STEP_W-1:0] step);
		cword_t cw;
		cw = '{op: OP_NOP, msel: MS_ANGLE, hold: HOLD_NONE, jcond: J_NONE, jtarget: ST_WAIT};
		case (step)
			ST_WAIT: begin
				cw.op   = OP_LOAD;
				cw.hold = HOLD_NO_ITEM;
			end
			ST_ANG_MUL: begin
				cw.op   = OP_MUL;
				cw.msel = MS_ANGLE;
			end
			ST_RERR:    cw.op = OP_RERR;
			ST_KP_MUL: begin
				cw.op   = OP_MUL;
				cw.msel = MS_KP;
			end
			ST_ACC_LD: begin
				// yaw has no derivative term
				cw.op      = OP_ACC_LD;
				cw.jcond   = J_YAW;
				cw.jtarget = ST_DIVPREP;
			end
			ST_KD_MUL: begin
				cw.op   = OP_MUL;
				cw.msel = MS_KD;
			end
			ST_ACC_ADD: cw.op = OP_ACC_ADD;
			ST_DIVPREP: cw.op = OP_DIVPREP;
			ST_RCP_MUL: begin
				cw.op   = OP_MUL;
				cw.msel = MS_RECIP;
			end
			ST_CORR: begin
				cw.op      = OP_CORR;
				cw.jcond   = J_MORE;
				cw.jtarget = ST_ANG_MUL;
			end
			ST_MIX: begin
				cw.op      = OP_MIX;
				cw.hold    = HOLD_OUT_BUSY;
				cw.jcond   = J_ALWAYS;
				cw.jtarget = ST_WAIT;
			end
			default: begin
				cw.jcond   = J_ALWAYS;
				cw.jtarget = ST_WAIT;
			end
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

FILE: design/qcpid_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module qcpid_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qcpid_pkg::seq_stat_t  stat,
	output qcpid_pkg::seq_ctrl_t  ctrl
);

	logic [qcpid_pkg::STEP_W-1:0] step_q;
	logic [qcpid_pkg::STEP_W-1:0] step_d;
	qcpid_pkg::cword_t            cw;
	logic                         hold;
	logic                         jump;

	always_comb begin
		cw = qcpid_pkg::ucode(step_q);
		case (cw.hold)
			qcpid_pkg::HOLD_NO_ITEM:  hold = !stat.item_valid;
			qcpid_pkg::HOLD_OUT_BUSY: hold = stat.out_busy;
			default:                  hold = 1'b0;
		endcase
		case (cw.jcond)
			qcpid_pkg::J_ALWAYS: jump = 1'b1;
			qcpid_pkg::J_YAW:    jump = stat.axis_yaw;
			qcpid_pkg::J_MORE:   jump = !stat.axis_yaw;
			default:             jump = 1'b0;
		endcase
		if (hold) begin
			step_d = step_q;
		end else if (jump) begin
			step_d = cw.jtarget;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= qcpid_pkg::ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	assign ctrl.op   = cw.op;
	assign ctrl.msel = cw.msel;
	assign ctrl.exec = !hold;
	assign ctrl.idle = (step_q == qcpid_pkg::ST_WAIT);

endmodule

`default_nettype wire

FILE: design/quadcopter_cascaded_pid_mixer_unit.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    angles, gyro rates, sticks, throttle, arm channel
// out       out_valid / out_ready  motor_one .. motor_four
// cfg       APB write/read         eight 16-bit gains, byte address 4*index
//
// An item is taken only in the wait step; the program then works through roll,
// pitch and yaw in turn (yaw skips the derivative steps) and then the mix, and
// no new item is taken before that. The single shared 33x33 multiplier sets this.
// Reset loads the gain reset values and clears the stored rate errors.
// The mix step waits while the previous result has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module quadcopter_cascaded_pid_mixer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// input item
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            roll_angle,
	input  logic signed [15:0]            pitch_angle,
	input  logic signed [15:0]            yaw_angle,
	input  logic signed [18:0]            roll_rate,
	input  logic signed [18:0]            pitch_rate,
	input  logic signed [18:0]            yaw_rate,
	input  logic        [11:0]            roll_stick,
	input  logic        [11:0]            pitch_stick,
	input  logic        [11:0]            throttle,
	input  logic        [11:0]            arm_channel,
	// result item
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [11:0]            motor_one,
	output logic        [11:0]            motor_two,
	output logic        [11:0]            motor_three,
	output logic        [11:0]            motor_four,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qcpid_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// gains
	logic [15:0] roll_rate_kp_q, roll_rate_kd_q, pitch_rate_kp_q, pitch_rate_kd_q;
	logic [15:0] yaw_rate_kp_q, roll_angle_kp_q, pitch_angle_kp_q, yaw_angle_kp_q;

	// captured item
	logic signed [15:0] roll_ang_q, pitch_ang_q, yaw_ang_q;
	logic signed [18:0] roll_rate_q, pitch_rate_q, yaw_rate_q;
	logic        [11:0] roll_stick_q, pitch_stick_q, thr_q, arm_q;

	// working registers
	logic [1:0]         axis_q;
	logic [63:0]        p_q;
	logic signed [23:0] e_q;
	logic signed [41:0] acc_q;
	logic [30:0]        n_q;
	logic               neg_q;
	logic signed [27:0] corr_roll_q, corr_pitch_q, corr_yaw_q;
	logic signed [23:0] last_roll_q, last_pitch_q;

	// result register
	logic        out_valid_q;
	logic [11:0] m1_q, m2_q, m3_q, m4_q;

	qcpid_pkg::seq_ctrl_t ctrl;
	qcpid_pkg::seq_stat_t stat;

	logic cfg_wr;
	logic [qcpid_pkg::REG_IDX_W-1:0] cfg_idx;

	// per-axis selections
	logic signed [15:0] ang_sel;
	logic signed [18:0] rate_sel;
	logic signed [15:0] tgt_sel;
	logic [15:0]        akp_sel, kp_sel, kd_sel;
	logic signed [23:0] last_sel;

	logic signed [13:0] roll_off, pitch_off;
	logic signed [15:0] roll_tgt, pitch_tgt;
	logic signed [16:0] diff;
	logic signed [24:0] de;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic signed [33:0] rt_sum;
	logic signed [26:0] rte;
	logic signed [23:0] e_sat;
	logic signed [41:0] mag;
	logic [26:0]        quo;
	logic signed [27:0] corr;
	logic signed [29:0] s1, s2, s3, s4;
	logic signed [29:0] thr_x, cr_x, cp_x, cy_x;

	function automatic logic [11:0] sat_motor(input logic signed [29:0] s);
		logic [11:0] r;
		if (s[29]) begin
			r = 12'd0;
		end else if (|s[28:12]) begin
			r = qcpid_pkg::MOTOR_MAX;
		end else begin
			r = s[11:0];
		end
		return r;
	endfunction

	qcpid_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign stat.item_valid = in_valid;
	assign stat.out_busy   = out_valid_q && !out_ready;
	assign stat.axis_yaw   = (axis_q == qcpid_pkg::AXIS_YAW);

	assign in_ready  = ctrl.idle;
	assign out_valid = out_valid_q;
	assign motor_one   = m1_q;
	assign motor_two   = m2_q;
	assign motor_three = m3_q;
	assign motor_four  = m4_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[qcpid_pkg::REG_IDX_W+1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_rate_kp_q   <= qcpid_pkg::RST_ROLL_RATE_KP;
			roll_rate_kd_q   <= qcpid_pkg::RST_ROLL_RATE_KD;
			pitch_rate_kp_q  <= qcpid_pkg::RST_PITCH_RATE_KP;
			pitch_rate_kd_q  <= qcpid_pkg::RST_PITCH_RATE_KD;
			yaw_rate_kp_q    <= qcpid_pkg::RST_YAW_RATE_KP;
			roll_angle_kp_q  <= qcpid_pkg::RST_ROLL_ANGLE_KP;
			pitch_angle_kp_q <= qcpid_pkg::RST_PITCH_ANGLE_KP;
			yaw_angle_kp_q   <= qcpid_pkg::RST_YAW_ANGLE_KP;
		end else if (cfg_wr) begin
			case (cfg_idx)
				qcpid_pkg::REG_ROLL_RATE_KP:   roll_rate_kp_q   <= pwdata[15:0];
				qcpid_pkg::REG_ROLL_RATE_KD:   roll_rate_kd_q   <= pwdata[15:0];
				qcpid_pkg::REG_PITCH_RATE_KP:  pitch_rate_kp_q  <= pwdata[15:0];
				qcpid_pkg::REG_PITCH_RATE_KD:  pitch_rate_kd_q  <= pwdata[15:0];
				qcpid_pkg::REG_YAW_RATE_KP:    yaw_rate_kp_q    <= pwdata[15:0];
				qcpid_pkg::REG_ROLL_ANGLE_KP:  roll_angle_kp_q  <= pwdata[15:0];
				qcpid_pkg::REG_PITCH_ANGLE_KP: pitch_angle_kp_q <= pwdata[15:0];
				qcpid_pkg::REG_YAW_ANGLE_KP:   yaw_angle_kp_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			qcpid_pkg::REG_ROLL_RATE_KP:   prdata = {16'd0, roll_rate_kp_q};
			qcpid_pkg::REG_ROLL_RATE_KD:   prdata = {16'd0, roll_rate_kd_q};
			qcpid_pkg::REG_PITCH_RATE_KP:  prdata = {16'd0, pitch_rate_kp_q};
			qcpid_pkg::REG_PITCH_RATE_KD:  prdata = {16'd0, pitch_rate_kd_q};
			qcpid_pkg::REG_YAW_RATE_KP:    prdata = {16'd0, yaw_rate_kp_q};
			qcpid_pkg::REG_ROLL_ANGLE_KP:  prdata = {16'd0, roll_angle_kp_q};
			qcpid_pkg::REG_PITCH_ANGLE_KP: prdata = {16'd0, pitch_angle_kp_q};
			default:                       prdata = {16'd0, yaw_angle_kp_q};
		endcase
	end

	// ---------------- datapath ----------------
	// roll target = (stick - 1500) * 4, pitch target = (1500 - stick) * 3
	assign roll_off  = $signed({2'b00, roll_stick_q}) - $signed(qcpid_pkg::STICK_CENTER);
	assign pitch_off = $signed(qcpid_pkg::STICK_CENTER) - $signed({2'b00, pitch_stick_q});
	assign roll_tgt  = {roll_off, 2'b00};
	assign pitch_tgt = {pitch_off[13], pitch_off, 1'b0} + {{2{pitch_off[13]}}, pitch_off};

	always_comb begin
		case (axis_q)
			qcpid_pkg::AXIS_ROLL: begin
				ang_sel  = roll_ang_q;
				rate_sel = roll_rate_q;
				tgt_sel  = roll_tgt;
				akp_sel  = roll_angle_kp_q;
				kp_sel   = roll_rate_kp_q;
				kd_sel   = roll_rate_kd_q;
				last_sel = last_roll_q;
			end
			qcpid_pkg::AXIS_PITCH: begin
				ang_sel  = pitch_ang_q;
				rate_sel = pitch_rate_q;
				tgt_sel  = pitch_tgt;
				akp_sel  = pitch_angle_kp_q;
				kp_sel   = pitch_rate_kp_q;
				kd_sel   = pitch_rate_kd_q;
				last_sel = last_pitch_q;
			end
			default: begin
				ang_sel  = yaw_ang_q;
				rate_sel = yaw_rate_q;
				tgt_sel  = 16'sd0;
				akp_sel  = yaw_angle_kp_q;
				kp_sel   = yaw_rate_kp_q;
				kd_sel   = 16'd0;
				last_sel = 24'sd0;
			end
		endcase
	end

	assign diff = {tgt_sel[15], tgt_sel} - {ang_sel[15], ang_sel};
	assign de   = {e_q[23], e_q} - {last_sel[23], last_sel};

	always_comb begin
		case (ctrl.msel)
			qcpid_pkg::MS_ANGLE: begin
				mul_a = {17'd0, akp_sel};
				mul_b = {{16{diff[16]}}, diff};
			end
			qcpid_pkg::MS_KP: begin
				mul_a = {17'd0, kp_sel};
				mul_b = {{9{e_q[23]}}, e_q};
			end
			qcpid_pkg::MS_KD: begin
				mul_a = {17'd0, kd_sel};
				mul_b = {{8{de[24]}}, de};
			end
			default: begin
				mul_a = {2'b00, n_q};
				mul_b = {1'b0, qcpid_pkg::RECIP_25};
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// rate target: product / 256 toward zero, then minus gyro rate, saturated
	assign rt_sum = $signed(p_q[33:0]) + (p_q[33] ? 34'sd255 : 34'sd0);
	assign rte    = {rt_sum[33], rt_sum[33:8]} - {{8{rate_sel[18]}}, rate_sel};

	always_comb begin
		if (rte[26:23] == 4'b0000 || rte[26:23] == 4'b1111) begin
			e_sat = rte[23:0];
		end else if (rte[26]) begin
			e_sat = qcpid_pkg::ERR_MIN;
		end else begin
			e_sat = qcpid_pkg::ERR_MAX;
		end
	end

	assign mag  = acc_q[41] ? -acc_q : acc_q;
	assign quo  = p_q[62:36];
	assign corr = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	// mixer
	assign thr_x = {18'd0, thr_q};
	assign cr_x  = {{2{corr_roll_q[27]}}, corr_roll_q};
	assign cp_x  = {{2{corr_pitch_q[27]}}, corr_pitch_q};
	assign cy_x  = {{2{corr_yaw_q[27]}}, corr_yaw_q};
	assign s1 = thr_x + cr_x + cp_x - cy_x;
	assign s2 = thr_x - cr_x + cp_x + cy_x;
	assign s3 = thr_x + cr_x - cp_x + cy_x;
	assign s4 = thr_x - cr_x - cp_x - cy_x;

	// payload and working registers
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			case (ctrl.op)
				qcpid_pkg::OP_LOAD: begin
					roll_ang_q    <= roll_angle;
					pitch_ang_q   <= pitch_angle;
					yaw_ang_q     <= yaw_angle;
					roll_rate_q   <= roll_rate;
					pitch_rate_q  <= pitch_rate;
					yaw_rate_q    <= yaw_rate;
					roll_stick_q  <= roll_stick;
					pitch_stick_q <= pitch_stick;
					thr_q         <= throttle;
					arm_q         <= arm_channel;
				end
				qcpid_pkg::OP_MUL:     p_q   <= prod[63:0];
				qcpid_pkg::OP_RERR:    e_q   <= e_sat;
				qcpid_pkg::OP_ACC_LD:  acc_q <= $signed(p_q[41:0]);
				qcpid_pkg::OP_ACC_ADD: acc_q <= acc_q + $signed(p_q[41:0]);
				qcpid_pkg::OP_DIVPREP: begin
					n_q   <= mag[40:10];
					neg_q <= acc_q[41];
				end
				qcpid_pkg::OP_CORR: begin
					case (axis_q)
						qcpid_pkg::AXIS_ROLL:  corr_roll_q  <= corr;
						qcpid_pkg::AXIS_PITCH: corr_pitch_q <= corr;
						default:               corr_yaw_q   <= corr;
					endcase
				end
				qcpid_pkg::OP_MIX: begin
					if (arm_q <= qcpid_pkg::DISARM_LEVEL) begin
						m1_q <= qcpid_pkg::DISARM_PULSE;
						m2_q <= qcpid_pkg::DISARM_PULSE;
						m3_q <= qcpid_pkg::DISARM_PULSE;
						m4_q <= qcpid_pkg::DISARM_PULSE;
					end else begin
						m1_q <= sat_motor(s1);
						m2_q <= sat_motor(s2);
						m3_q <= sat_motor(s3);
						m4_q <= sat_motor(s4);
					end
				end
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q      <= qcpid_pkg::AXIS_ROLL;
			last_roll_q <= 24'sd0;
			last_pitch_q <= 24'sd0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.exec && ctrl.op == qcpid_pkg::OP_LOAD) begin
				axis_q <= qcpid_pkg::AXIS_ROLL;
			end else if (ctrl.exec && ctrl.op == qcpid_pkg::OP_CORR) begin
				axis_q <= axis_q + 1'b1;
				// the stored error of this axis has been used; keep the new one
				if (axis_q == qcpid_pkg::AXIS_ROLL) begin
					last_roll_q <= e_q;
				end else if (axis_q == qcpid_pkg::AXIS_PITCH) begin
					last_pitch_q <= e_q;
				end
			end
			if (ctrl.exec && ctrl.op == qcpid_pkg::OP_MIX) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/qcpid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "quadcopter_cascaded_pid_mixer_unit_assert.svh"

module qcpid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] motor_one,
	input logic [11:0] motor_two,
	input logic [11:0] motor_three,
	input logic [11:0] motor_four
);

	// one item at a time: taking an item closes the input
	`QCPID_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

	// the input reopens exactly when a result is posted
	`QCPID_ASSERT_SAME(a_reopen_with_result, $rose(in_ready), out_valid)

	`QCPID_ASSERT_SAME(a_result_when_idle, $rose(out_valid), in_ready)

	// a stalled result holds
	`QCPID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(motor_one) && $stable(motor_two) && $stable(motor_three) && $stable(motor_four))

endmodule

bind quadcopter_cascaded_pid_mixer_unit qcpid_checker u_qcpid_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.motor_one   (motor_one),
	.motor_two   (motor_two),
	.motor_three (motor_three),
	.motor_four  (motor_four)
);

`default_nettype wire
